// ===== src/fdh_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdh_pkg
// Types, character codes and the times-33 mixing function of the filtered
// record hash.
// ============================================================================
package fdh_pkg;

    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_COLON = 8'h3A;
    localparam logic [7:0]  CHAR_EQUAL = 8'h3D;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CASE_BIT   = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       field_end;
        logic       record_end;
    } fdh_item_t;

    typedef struct packed {
        logic [31:0] hash;
        logic        zero_pending;
    } fdh_state_t;

    function automatic logic [31:0] mix33(input logic [31:0] h, input logic [7:0] c);
        mix33 = {h[26:0], 5'b0} + h + {24'b0, c};
    endfunction

endpackage

// ===== src/filtered_djb2_record_hash.sv =====
`timescale 1ns / 1ps
// ============================================================================
// filtered_djb2_record_hash
// Times-33 record hash over filtered bytes, one byte per clock unless stalled.
// ============================================================================
// Items enter on the in channel (in_valid/in_ready) with data_byte,
// byte_present, field_end and record_end. An item is captured in an input
// register and, when it fires, updates the running hash through the
// step logic. An item with record_end loads the finished hash into the
// output register, which drives the out channel (out_valid/out_ready) with
// hash_value; the running hash then restarts at 5381.
// Throughput is one item per clock unless a record end waits for the output.
// When the receiver stalls, the output register holds its hash while items
// without record_end keep flowing; an item with record_end waits in the input
// register until the output register is free, and in_ready falls only then.
// Reset empties both registers, sets the running hash to 5381 and clears the
// held zero.
// ============================================================================
module filtered_djb2_record_hash
    import fdh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        field_end,
    input  logic        record_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    fdh_item_t   item_reg;
    logic        item_valid_reg;
    fdh_state_t  state_reg;
    fdh_state_t  state_next;
    logic        out_valid_reg;
    logic [31:0] hash_value_reg;
    logic [31:0] record_hash;
    logic        out_free;
    logic        item_fire;

    assign out_free  = !out_valid_reg || out_ready;
    assign item_fire = item_valid_reg && (!item_reg.record_end || out_free);
    assign in_ready  = !item_valid_reg || item_fire;

    fdh_hash_step u_step
    (
        .item        (item_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .record_hash (record_hash)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg         <= 1'b0;
            state_reg.hash         <= HASH_SEED;
            state_reg.zero_pending <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (item_fire)
            begin
                state_reg <= state_next;
            end
            if (item_fire && item_reg.record_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.data_byte    <= data_byte;
            item_reg.byte_present <= byte_present;
            item_reg.field_end    <= field_end;
            item_reg.record_end   <= record_end;
        end
        if (item_fire && item_reg.record_end)
        begin
            hash_value_reg <= record_hash;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_value_reg;

    // A finished record leaves the block with a fresh seed and no held zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item_reg.record_end |=>
            out_valid && (state_reg.hash == HASH_SEED) && !state_reg.zero_pending)
        else $error("record end did not publish the hash and restart");

    // A zero is only held after a present zero byte was processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.zero_pending) |->
            $past(item_fire && item_reg.byte_present && (item_reg.data_byte == CHAR_ZERO)))
        else $error("zero held without a zero byte");

    // A stalled output never blocks items that do not end a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !item_reg.record_end |-> in_ready)
        else $error("input stalled by an item that needs no output");

    // The running hash only changes when an item is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_fire |=> $stable(state_reg))
        else $error("hash state changed without an item");

endmodule

// ===== src/fdh_hash_step.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdh_hash_step
// Next-state logic for one item: filtering of the byte, handling of a held
// zero, and at most two times-33 updates of the running hash.
// ============================================================================
module fdh_hash_step
    import fdh_pkg::*;
(
    input  fdh_item_t   item,
    input  fdh_state_t  state,
    output fdh_state_t  state_next,
    output logic [31:0] record_hash
);

    logic        is_blank;
    logic        colon_kill;
    logic        flush_first;
    logic        byte_hold;
    logic        byte_mix;
    logic        pend_after;
    logic        end_flush;
    logic        second_mix;
    logic [7:0]  second_char;
    logic [31:0] hash_a;
    logic [31:0] hash_b;

    assign is_blank    = item.data_byte inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
    assign colon_kill  = item.byte_present && state.zero_pending
                         && (item.data_byte == CHAR_COLON);
    assign flush_first = item.byte_present && state.zero_pending && !colon_kill;
    assign byte_hold   = item.byte_present && !colon_kill
                         && (item.data_byte == CHAR_ZERO) && !item.field_end;
    assign byte_mix    = item.byte_present && !colon_kill && !byte_hold
                         && !is_blank && (item.data_byte != CHAR_EQUAL);
    assign pend_after  = item.byte_present ? byte_hold : state.zero_pending;
    assign end_flush   = (item.field_end || item.record_end) && pend_after;
    assign second_mix  = byte_mix || end_flush;
    assign second_char = byte_mix ? (item.data_byte | CASE_BIT) : CHAR_ZERO;

    assign hash_a = flush_first ? mix33(state.hash, CHAR_ZERO) : state.hash;
    assign hash_b = second_mix ? mix33(hash_a, second_char) : hash_a;

    assign record_hash = hash_b;

    always_comb
    begin
        if (item.record_end)
        begin
            state_next.hash         = HASH_SEED;
            state_next.zero_pending = 1'b0;
        end
        else
        begin
            state_next.hash         = hash_b;
            state_next.zero_pending = pend_after && !end_flush;
        end
    end

endmodule

// ===== tb/sv/tb_filtered_djb2_record_hash.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_filtered_djb2_record_hash
// Self-checking bench for the filtered times-33 record hash.
// ============================================================================
// A short table of directed items covers the byte extremes, case folding,
// dropped whitespace and '=', and every way a held '0' is resolved. Random
// records follow, made of fields biased toward '0', ':', '=' and blanks, with
// some stray items mixed in. Every accepted item runs through a local model
// of the hash. Each hash that leaves the block is compared with the oldest
// expected one, the model's or a known row's. Both sides idle and stall at
// random, and the sender sometimes waits for the block to drain.
// ============================================================================
module tb_filtered_djb2_record_hash;
    import fdh_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        fdh_item_t   item;
        bit          known;
        logic [31:0] hash;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        field_end;
    logic        record_end;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash_value;

    logic [31:0] model_hash;
    bit          model_zero_held;
    logic [31:0] expected_hashes[$];
    logic [31:0] oldest_hash;
    stim_row_t   directed_rows[$];
    int          error_count;
    int          cycle_count;
    int          sent_items;
    int          sender_calm;
    int          stall_left;
    int          receiver_calm;

    filtered_djb2_record_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .field_end    (field_end),
        .record_end   (record_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at cycle %0d: %s, expected %08h, got %08h",
                 cycle_count, what, want, got);
        error_count++;
    endtask

    function automatic void fold_byte(input logic [7:0] b);
        model_hash = model_hash * 32'd33 + {24'd0, b | CASE_BIT};
    endfunction

    function automatic void release_zero();
        if (model_zero_held)
        begin
            fold_byte(CHAR_ZERO);
            model_zero_held = 1'b0;
        end
    endfunction

    function automatic bit record_hash_step(input fdh_item_t it, output logic [31:0] digest);
        logic [7:0] b;
        b = it.data_byte;
        digest = '0;
        if (it.byte_present)
        begin
            if (model_zero_held && b == CHAR_COLON)
                model_zero_held = 1'b0;
            else
            begin
                release_zero();
                if (b == CHAR_ZERO && !it.field_end)
                    model_zero_held = 1'b1;
                else if (!((b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_SPACE ||
                           b == CHAR_EQUAL))
                    fold_byte(b);
            end
        end
        if (it.field_end || it.record_end)
            release_zero();
        if (it.record_end)
        begin
            digest = model_hash;
            model_hash = HASH_SEED;
            model_zero_held = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int sender_gap();
        int r;
        if (sender_calm > 0)
        begin
            sender_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
            sender_calm = $urandom_range(20, 80);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (receiver_calm > 0)
                receiver_calm--;
            else if ($urandom_range(0, 99) == 0)
                receiver_calm = $urandom_range(30, 150);
            else if ($urandom_range(0, 2) == 0)
                stall_left = stall_length();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hashes.size() == 0)
                report_mismatch("hash with none pending", '0, hash_value);
            else
            begin
                oldest_hash = expected_hashes.pop_front();
                if (hash_value !== oldest_hash)
                    report_mismatch("hash_value", oldest_hash, hash_value);
            end
        end
    end

    task automatic send_item(input fdh_item_t it, input bit known, input logic [31:0] typed);
        logic [31:0] digest;
        int gap;
        data_byte    <= it.data_byte;
        byte_present <= it.byte_present;
        field_end    <= it.field_end;
        record_end   <= it.record_end;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (record_hash_step(it, digest))
            expected_hashes.insert(expected_hashes.size(), known ? typed : digest);
        if (it.byte_present || it.field_end || it.record_end)
            sent_items++;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_hashes.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic p, input logic f, input logic r,
                           input bit known, input logic [31:0] hash);
        stim_row_t row;
        row.item  = '{b, p, f, r};
        row.known = known;
        row.hash  = hash;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 9))
            0, 1: return CHAR_ZERO;
            2: return CHAR_COLON;
            3: return CHAR_EQUAL;
            4: return ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                   : CHAR_TAB + 8'($urandom_range(0, 4));
            5: return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_record();
        int fields;
        int len;
        bit last;
        bit inline_end;
        bit inline_record;
        fdh_item_t it;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++)
        begin
            last = (f == fields - 1);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
            inline_end = (len > 0) && ($urandom_range(0, 1) == 1);
            inline_record = inline_end && last && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
            begin
                it = '{text_byte(), 1'b1, 1'b0, 1'b0};
                if (i == len - 1)
                begin
                    it.field_end  = inline_end;
                    it.record_end = inline_record;
                end
                send_item(it, 1'b0, '0);
            end
            if (!inline_end || (last && !inline_record))
            begin
                it = '{8'($urandom_range(0, 255)), 1'b0, 1'b1, last};
                if (inline_end || $urandom_range(0, 9) == 0)
                    it.field_end = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        fdh_item_t noise;
        int next_drain;
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        data_byte       = '0;
        byte_present    = 1'b0;
        field_end       = 1'b0;
        record_end      = 1'b0;
        out_ready       = 1'b0;
        model_hash      = HASH_SEED;
        model_zero_held = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        sent_items      = 0;
        sender_calm     = 0;
        stall_left      = 0;
        receiver_calm   = 0;

        add_row(8'hFF,      1'b0, 1'b0, 1'b1, 1'b1, 32'd5381);
        add_row(8'h61,      1'b1, 1'b0, 1'b1, 1'b1, 32'd177670);
        add_row(8'h41,      1'b1, 1'b0, 1'b1, 1'b1, 32'd177670);
        add_row(8'h00,      1'b1, 1'b0, 1'b1, 1'b1, 32'd177605);
        add_row(8'hFF,      1'b1, 1'b1, 1'b1, 1'b1, 32'd177828);
        add_row(CHAR_ZERO,  1'b1, 1'b1, 1'b1, 1'b1, 32'd177621);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_COLON, 1'b1, 1'b0, 1'b1, 1'b1, 32'd5381);
        add_row(CHAR_SPACE, 1'b1, 1'b0, 1'b1, 1'b1, 32'd5381);
        add_row(CHAR_EQUAL, 1'b1, 1'b0, 1'b1, 1'b1, 32'd5381);
        add_row(CHAR_CR,    1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h0E,      1'b1, 1'b0, 1'b1, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h78,      1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(CHAR_COLON, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00,      1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_COLON, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_COLON, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(CHAR_ZERO,  1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(CHAR_COLON, 1'b0, 1'b0, 1'b1, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].hash);
        drain_block();

        sent_items = 0;
        next_drain = 250;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (sent_items >= next_drain)
            begin
                drain_block();
                next_drain += 250;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                noise = '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0)};
                send_item(noise, 1'b0, '0);
            end
            else
                send_record();
        end

        drain_block();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        @(posedge clk);
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filtered_djb2_record_hash.f =====
src/fdh_pkg.sv
src/fdh_hash_step.sv
src/filtered_djb2_record_hash.sv
tb/sv/tb_filtered_djb2_record_hash.sv
